/* src/assert_macros.svh */
// Assertion macros shared by the LED strip framer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lsf_pkg.sv */
// Package for the LED strip serial framer: constants, payload types,
// frame phase enum and the controller/datapath command and status structs.
package lsf_pkg;

  localparam int MAX_LEDS = 64;
  localparam int ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W    = $clog2(MAX_LEDS + 1);
  localparam int PIX_W    = 24;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_START  = 2'd1,
    PH_PIXELS = 2'd2,
    PH_END    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lsf_in_t;

  typedef struct packed {
    logic sclk_pulse;
    logic serial_data;
    logic busy_res;
    logic frame_end;
    logic rejected;
  } lsf_out_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic start;
    logic bit_adv;
    logic byte_adv;
    logic pix_adv;
    logic pix_clr;
    logic frame_done;
    logic in_pixels;
    logic rejected;
    logic busy_nxt;
  } lsf_cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic bit_last;
    logic byte_last;
    logic pix_last;
  } lsf_stat_t;

endpackage

/* src/led_strip_serial_framer.sv */
// LED strip serial framer top level: one transaction in, one result transaction out.
// The result appears in the cycle after acceptance; throughput is one transaction per cycle
// while out_ready is high, set by the phase FSM and the registered pixel store read ahead.
// Reset (rst_n, synchronous, active low) empties the pixel count and idles the frame.
// Depends on lsf_pkg, lsf_ctrl, lsf_dp, lsf_ram and assert_macros.svh.
`include "assert_macros.svh"

module led_strip_serial_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsf_pkg::lsf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lsf_pkg::lsf_out_t out_data
);
  import lsf_pkg::*;

  lsf_cmd_t  cmd;
  lsf_stat_t stat;

  lsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  `ASSERT_IMPLIES(a_no_write_when_full, clk, rst_n, cmd.wr, !stat.full, "store write while full")
  `ASSERT_NEXT(a_count_clear_after_frame, clk, rst_n, cmd.frame_done, stat.count_zero, "count not cleared")
  `ASSERT_IMPLIES(a_end_not_busy, clk, rst_n, out_valid && out_data.frame_end, !out_data.busy_res, "frame end while busy")
  `ASSERT_IMPLIES(a_data_needs_pulse, clk, rst_n, out_valid && out_data.serial_data, out_data.sclk_pulse, "data without clock pulse")

endmodule

/* src/lsf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/lsf_ctrl.sv */
// Controller of the LED strip framer: handshake, command decode and frame phase FSM.
// Depends on lsf_pkg; drives the datapath through lsf_cmd_t.
module lsf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  input  lsf_pkg::lsf_stat_t stat,
  output lsf_pkg::lsf_cmd_t  cmd
);
  import lsf_pkg::*;

  phase_t    phase_r, phase_nxt;
  logic      out_valid_r, out_valid_nxt;
  cmd_code_t code;
  logic      acc;
  logic      busy;
  logic      tick;
  logic      start_ok;

  assign code     = cmd_code_t'(in_cmd);
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign busy     = (phase_r != PH_IDLE);
  assign tick     = acc && (code == CMD_TICK) && busy;
  assign start_ok = acc && (code == CMD_START) && !busy;

  always_comb begin
    phase_nxt = phase_r;
    if (start_ok) begin
      phase_nxt = PH_START;
    end else if (tick && stat.bit_last) begin
      unique case (phase_r)
        PH_START: begin
          if (stat.byte_last) begin
            phase_nxt = stat.count_zero ? PH_IDLE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (stat.byte_last && stat.pix_last) begin
            phase_nxt = PH_END;
          end
        end
        PH_END: begin
          if (stat.pix_last) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = acc;
    cmd.wr         = acc && (code == CMD_STORE) && !busy && !stat.full;
    cmd.start      = start_ok;
    cmd.rejected   = acc && (((code == CMD_STORE) && (busy || stat.full)) ||
                             ((code == CMD_START) && busy));
    cmd.bit_adv    = tick;
    cmd.in_pixels  = (phase_r == PH_PIXELS);
    cmd.busy_nxt   = (phase_nxt != PH_IDLE);
    if (tick && stat.bit_last) begin
      unique case (phase_r)
        PH_START: begin
          cmd.byte_adv   = 1'b1;
          cmd.frame_done = stat.byte_last && stat.count_zero;
          cmd.pix_clr    = stat.byte_last;
        end
        PH_PIXELS: begin
          cmd.byte_adv = 1'b1;
          cmd.pix_adv  = stat.byte_last;
          cmd.pix_clr  = stat.byte_last && stat.pix_last;
        end
        PH_END: begin
          cmd.pix_adv    = 1'b1;
          cmd.frame_done = stat.pix_last;
          cmd.pix_clr    = stat.pix_last;
        end
        default: begin
          cmd.byte_adv = 1'b0;
        end
      endcase
    end
    if (start_ok) begin
      cmd.pix_clr = 1'b1;
    end
  end

  assign out_valid_nxt = acc || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/lsf_dp.sv */
// Datapath of the LED strip framer: pixel store, counters, bit select and result register.
// Depends on lsf_pkg and lsf_ram; steered by lsf_ctrl through lsf_cmd_t.
module lsf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lsf_pkg::lsf_in_t   in_data,
  input  lsf_pkg::lsf_cmd_t  cmd,
  output lsf_pkg::lsf_stat_t stat,
  output lsf_pkg::lsf_out_t  out_data
);
  import lsf_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pix_idx_r, pix_idx_nxt;
  logic [1:0]       byte_idx_r, byte_idx_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic [PIX_W-1:0] pix_q;
  logic [PIX_W-1:0] pix_wdata;
  logic [7:0]       cur_byte;
  logic             cur_bit;
  lsf_out_t         out_r, out_nxt;

  assign pix_wdata = {in_data.red, in_data.green, in_data.blue};

  lsf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (pix_wdata),
    .raddr (pix_idx_r[ADDR_W-1:0]),
    .rdata (pix_q)
  );

  assign stat.full       = (count_r >= CNT_W'(MAX_LEDS));
  assign stat.count_zero = (count_r == '0);
  assign stat.bit_last   = (bit_idx_r == 3'd7);
  assign stat.byte_last  = (byte_idx_r == 2'd3);
  assign stat.pix_last   = (({1'b0, pix_idx_r} + (CNT_W + 1)'(1)) >= {1'b0, count_r});

  always_comb begin
    if (!cmd.in_pixels) begin
      cur_byte = ZERO_BYTE;
    end else begin
      case (byte_idx_r)
        2'd0:    cur_byte = HDR_BYTE;
        2'd1:    cur_byte = pix_q[7:0];
        2'd2:    cur_byte = pix_q[15:8];
        default: cur_byte = pix_q[23:16];
      endcase
    end
  end

  assign cur_bit = cur_byte[3'd7 - bit_idx_r];

  always_comb begin
    count_nxt    = count_r;
    pix_idx_nxt  = pix_idx_r;
    byte_idx_nxt = byte_idx_r;
    bit_idx_nxt  = bit_idx_r;
    if (cmd.wr) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.frame_done) begin
      count_nxt = '0;
    end
    if (cmd.start) begin
      byte_idx_nxt = '0;
      bit_idx_nxt  = '0;
    end
    if (cmd.bit_adv) begin
      bit_idx_nxt = bit_idx_r + 3'd1;
    end
    if (cmd.byte_adv) begin
      byte_idx_nxt = byte_idx_r + 2'd1;
    end
    if (cmd.pix_clr) begin
      pix_idx_nxt = '0;
    end else if (cmd.pix_adv) begin
      pix_idx_nxt = pix_idx_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt             = out_r;
    if (cmd.load) begin
      out_nxt.sclk_pulse  = cmd.bit_adv;
      out_nxt.serial_data = cmd.bit_adv && cur_bit;
      out_nxt.busy_res    = cmd.busy_nxt;
      out_nxt.frame_end   = cmd.frame_done;
      out_nxt.rejected    = cmd.rejected;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pix_idx_r  <= '0;
      byte_idx_r <= '0;
      bit_idx_r  <= '0;
    end else begin
      count_r    <= count_nxt;
      pix_idx_r  <= pix_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
      bit_idx_r  <= bit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
